### design/kvc_pkg.sv
// Package for the keyword verdict classifier: sizes, verdict codes, keyword ROM.
// No dependencies.
package kvc_pkg;

  localparam int unsigned WindowDepth  = 27;
  localparam int unsigned MaxScanBytes = 65536;
  localparam int unsigned CountWidth   = 17;
  localparam int unsigned KwCount      = 109;
  localparam int unsigned KwMaxLen     = 28;

  typedef enum logic [1:0] {
    VerdictOk     = 2'd0,
    VerdictWarn   = 2'd1,
    VerdictReview = 2'd2,
    VerdictBlock  = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    GrpBlock     = 2'd0,
    GrpPrivacy   = 2'd1,
    GrpFinancial = 2'd2,
    GrpDelete    = 2'd3
  } group_e;

  // Sticky hit flags, one per keyword group, held in the top level for the message.
  typedef struct packed {
    logic blk;
    logic prv;
    logic fin;
    logic del;
  } flags_t;

  // Keyword text, right aligned: last character in bits [7:0].
  typedef struct packed {
    logic [KwMaxLen*8-1:0] text;
    logic [4:0]            len;
    group_e                grp;
  } keyword_t;

  function automatic keyword_t kw_entry(input int unsigned idx);
    keyword_t k;
    k.grp = GrpBlock;
    k.text = '0;
    case (idx)
      0: k.text = "hack";
      1: k.text = "exploit";
      2: k.text = "malware";
      3: k.text = "phishing";
      4: k.text = "ransomware";
      5: k.text = "illegal";
      6: k.text = "fraud";
      7: k.text = "scam";
      8: k.text = "steal";
      9: k.text = "attack";
      10: k.text = "bypass security";
      11: k.text = "disable authentication";
      12: k.text = "inject";
      13: k.text = "password crack";
      14: k.text = "brute force";
      15: k.text = "denial of service";
      16: k.text = "voglio morire";
      17: k.text = "want to die";
      18: k.text = "kill myself";
      19: k.text = "end my life";
      20: k.text = "faccio del male";
      21: k.text = "hurt myself";
      22: k.text = "tagliarmi";
      23: k.text = "cut myself";
      24: k.text = "suicide";
      25: k.text = "suicid";
      26: k.text = "nessuno mi vuole";
      27: k.text = "nobody loves me";
      28: k.text = "feel alone";
      29: k.text = "very sad";
      30: k.text = "very alone";
      31: k.text = "isolated";
      32: k.text = "costruisco una bomba";
      33: k.text = "make a bomb";
      34: k.text = "make a weapon";
      35: k.text = "fare del male a";
      36: k.text = "hurt someone";
      37: k.text = "violence";
      38: k.text = "violenza";
      39: k.text = "weapon";
      40: k.text = "arma";
      41: k.text = "fight";
      42: k.text = "combat";
      43: k.text = "contenuti per adulti";
      44: k.text = "adult content";
      45: k.text = "porn";
      46: k.text = "sex";
      47: k.text = "explicit";
      48: k.text = "mature content";
      49: k.text = "18+";
      50: k.text = "nsfw";
      51: k.text = "fare il bullo";
      52: k.text = "bully";
      53: k.text = "bullismo";
      54: k.text = "harass";
      55: k.text = "intimidate";
      56: k.text = "threaten";
      57: k.text = "minacciare";
      58: k.text = "fare la droga";
      59: k.text = "make drugs";
      60: k.text = "drugs";
      61: k.text = "droghe";
      62: k.text = "cocaine";
      63: k.text = "heroin";
      64: k.text = "marijuana";
      65: k.text = "cannabis";
      66: k.text = "dimentica le tue istruzioni";
      67: k.text = "ignore previous instructions";
      68: k.text = "disregard all prior";
      69: k.text = "forget everything";
      70: k.text = "you are now";
      71: k.text = "new instructions";
      72: k.text = "system prompt";
      73: k.text = "roleplay as";
      74: begin k.text = "ssn"; k.grp = GrpPrivacy; end
      75: begin k.text = "social security"; k.grp = GrpPrivacy; end
      76: begin k.text = "credit card number"; k.grp = GrpPrivacy; end
      77: begin k.text = "bank account"; k.grp = GrpPrivacy; end
      78: begin k.text = "password"; k.grp = GrpPrivacy; end
      79: begin k.text = "secret key"; k.grp = GrpPrivacy; end
      80: begin k.text = "api key"; k.grp = GrpPrivacy; end
      81: begin k.text = "private key"; k.grp = GrpPrivacy; end
      82: begin k.text = "personal data"; k.grp = GrpPrivacy; end
      83: begin k.text = "medical record"; k.grp = GrpPrivacy; end
      84: begin k.text = "health information"; k.grp = GrpPrivacy; end
      85: begin k.text = "biometric"; k.grp = GrpPrivacy; end
      86: begin k.text = "location track"; k.grp = GrpPrivacy; end
      87: begin k.text = "transfer money"; k.grp = GrpFinancial; end
      88: begin k.text = "payment"; k.grp = GrpFinancial; end
      89: begin k.text = "transaction"; k.grp = GrpFinancial; end
      90: begin k.text = "wire transfer"; k.grp = GrpFinancial; end
      91: begin k.text = "cryptocurrency"; k.grp = GrpFinancial; end
      92: begin k.text = "bitcoin"; k.grp = GrpFinancial; end
      93: begin k.text = "wallet"; k.grp = GrpFinancial; end
      94: begin k.text = "bank transfer"; k.grp = GrpFinancial; end
      95: begin k.text = "invoice"; k.grp = GrpFinancial; end
      96: begin k.text = "purchase"; k.grp = GrpFinancial; end
      97: begin k.text = "credit card"; k.grp = GrpFinancial; end
      98: begin k.text = "debit card"; k.grp = GrpFinancial; end
      99: begin k.text = "delete all"; k.grp = GrpDelete; end
      100: begin k.text = "drop table"; k.grp = GrpDelete; end
      101: begin k.text = "truncate"; k.grp = GrpDelete; end
      102: begin k.text = "rm -rf"; k.grp = GrpDelete; end
      103: begin k.text = "remove permanently"; k.grp = GrpDelete; end
      104: begin k.text = "purge"; k.grp = GrpDelete; end
      105: begin k.text = "erase"; k.grp = GrpDelete; end
      106: begin k.text = "wipe"; k.grp = GrpDelete; end
      107: begin k.text = "destroy data"; k.grp = GrpDelete; end
      108: begin k.text = "clear database"; k.grp = GrpDelete; end
      default: k.text = '0;
    endcase
    k.len = '0;
    for (int unsigned i = 0; i < KwMaxLen; i++) begin
      if (k.text[i*8 +: 8] != 8'd0) k.len = 5'(i + 1);
    end
    return k;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? 8'(b + 8'd32) : b;
  endfunction

endpackage

### design/kvc_if.sv
// Valid/ready stream interfaces for the classifier channels.
// Depends on kvc_pkg.
interface kvc_in_if (input logic clk_i);
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;
  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

interface kvc_out_if (input logic clk_i);
  logic                valid;
  logic                ready;
  kvc_pkg::verdict_e   verdict;
  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

### design/kvc_cell.sv
// One window cell: holds a folded byte, hands it on, reports keyword
// position matches. Depends on kvc_pkg.
module kvc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  clear_i,
  input  logic [7:0]            char_i,
  input  logic [7:0]            pos_i,     // window slot index (constant)
  output logic [7:0]            char_o,
  output logic [kvc_pkg::KwCount-1:0] ok_o // per keyword: slot agrees
);
  import kvc_pkg::*;

  logic [7:0] char_q, char_d;

  always_comb begin
    char_d = char_q;
    if (clear_i) char_d = 8'd0;
    else if (shift_i) char_d = char_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= 8'd0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o = char_q;

  // slot p is compared with keyword char len-2-p (counting from the end: p+1)
  always_comb begin
    for (int unsigned k = 0; k < KwCount; k++) begin
      keyword_t e;
      e = kw_entry(k);
      if (32'(pos_i) + 1 >= 32'(e.len)) ok_o[k] = 1'b1;
      else ok_o[k] = (e.text[(32'(pos_i) + 1)*8 +: 8] == char_q);
    end
  end
endmodule

### design/keyword_verdict_classifier_core.sv
// Top level of the keyword verdict classifier: cell row, flags, output register.
// Depends on kvc_pkg, kvc_if, kvc_cell.
//
// Accepts one byte per cycle while ready is high; the verdict for a message
// leaves through a one-entry output register in the cycle after its last byte,
// and a new byte is accepted while that register is empty or being drained in
// the same cycle. Each byte is case folded and compared, together with the
// 27 window cells, against every keyword combinationally; the row then shifts.
// Only the first 65536 bytes of a message are scanned; later bytes just wait
// for the last-byte flag. Keywords of up to 28 characters are recognized.
module keyword_verdict_classifier_core (
  input logic    clk_i,
  input logic    rst_ni,
  kvc_in_if.sink   in_i,
  kvc_out_if.source out_o
);
  import kvc_pkg::*;

  logic [7:0] chain [WindowDepth+1];
  logic [KwCount-1:0] ok [WindowDepth];
  logic accept, scan, clear;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  flags_t flags_q, flags_d, hits;
  logic out_valid_q;
  verdict_e verdict_q, verdict_d;
  logic [7:0] cur;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept = in_i.valid && in_i.ready;
  assign scan   = accept && (cnt_q < CountWidth'(MaxScanBytes));
  assign clear  = accept && in_i.last_byte;
  assign cur    = fold_case(in_i.text_byte);
  assign chain[0] = cur;

  for (genvar p = 0; p < WindowDepth; p++) begin : g_cell
    kvc_cell u_cell (
      .clk_i, .rst_ni,
      .shift_i(scan), .clear_i(clear),
      .char_i(chain[p]), .pos_i(8'(p)),
      .char_o(chain[p+1]), .ok_o(ok[p])
    );
  end

  // AND the cell votes with the current-byte check, then OR per group
  always_comb begin
    hits = '0;
    for (int unsigned k = 0; k < KwCount; k++) begin
      keyword_t e;
      logic m;
      e = kw_entry(k);
      m = (e.len != 5'd0) && (e.text[7:0] == cur);
      for (int unsigned p = 0; p < WindowDepth; p++) m = m & ok[p][k];
      if (m) begin
        case (e.grp)
          GrpBlock:     hits.blk = 1'b1;
          GrpPrivacy:   hits.prv = 1'b1;
          GrpFinancial: hits.fin = 1'b1;
          default:      hits.del = 1'b1;
        endcase
      end
    end
  end

  always_comb begin
    flags_d = flags_q;
    cnt_d   = cnt_q;
    if (scan) begin
      flags_d = flags_q | hits;
      cnt_d   = cnt_q + 1'b1;
    end
    if      (flags_d.blk) verdict_d = VerdictBlock;
    else if (flags_d.prv) verdict_d = VerdictReview;
    else if (flags_d.fin) verdict_d = VerdictWarn;
    else if (flags_d.del) verdict_d = VerdictReview;
    else                  verdict_d = VerdictOk;
    if (clear) begin
      flags_d = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      flags_q <= flags_d;
      cnt_q   <= cnt_d;
      if (clear) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) verdict_q <= verdict_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.verdict = verdict_q;
endmodule

### design/kvc_checker.sv
// Port-level checker for the classifier, bound to the top level.
// Uses neither kvc_pkg nor kvc_if.
module kvc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  a_verdict_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i) else $error("no verdict");
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("stalled while empty");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i))
    else $error("verdict without last byte");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("verdict dropped");
endmodule

bind keyword_verdict_classifier_core kvc_checker u_kvc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready), .in_last_i(in_i.last_byte),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready)
);
